>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the upload credit rate controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every rising clock edge outside of reset
`define UPCR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("upcr: assertion failed");

// check prop on every rising clock edge, reset included
`define UPCR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("upcr: assertion failed");

`endif

>>> sv/upcr_pkg.sv
// ----------------------------------------------------------------------------
// upcr_pkg
// Widths, register indexes and fixed-point constants of the upload credit
// rate controller.
// ----------------------------------------------------------------------------
`default_nettype none

package upcr_pkg;

   localparam int ElapsedW  = 16;
   localparam int CountW    = 32;
   localparam int QW        = 24;
   localparam int MtuW      = 16;
   localparam int CreditW   = 48;
   localparam int RateW     = 32;
   localparam int CsrDataW  = 24;
   localparam int CsrIndexW = 2;

   typedef logic [CsrIndexW-1:0] csr_index_type;

   localparam csr_index_type CSR_MAX_UPLOAD_Q8 = 2'd0;
   localparam csr_index_type CSR_LINK_MTU      = 2'd1;
   localparam csr_index_type CSR_FULL_CONTROL  = 2'd2;

   localparam logic [MtuW-1:0] LINK_MTU_RESET = 16'd1500;

   localparam logic [CreditW-1:0] HEADER_BYTES = 48'd40;
   localparam logic [CreditW-1:0] MIN_RATE     = 48'd1024;

   // floor(x/5) = (x * RECIP) >> shift, exact over the operand range
   localparam logic [31:0] RECIP_5_W31 = 32'd3435973837;  // shift 34, x < 2^31
   localparam logic [24:0] RECIP_5_W24 = 25'd26843546;    // shift 27, x < 2^24
   // floor(r/125) = (r * RECIP) >> 34, exact for r < 2^27
   localparam logic [27:0] RECIP_125   = 28'd137438954;
   // 2^20 = 125 * 8388 + 76
   localparam logic [13:0] DIV125_HI_QUOT = 14'd8388;
   localparam logic [6:0]  DIV125_HI_REM  = 7'd76;

   // floor(4*j/5) for a remainder j of a division by five
   function automatic logic [1:0] frac_4_5(input logic [2:0] rem);
      logic [1:0] f;
      case (rem)
         3'd0:    f = 2'd0;
         3'd1:    f = 2'd0;
         3'd2:    f = 2'd1;
         3'd3:    f = 2'd2;
         3'd4:    f = 2'd3;
         default: f = 2'd0;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

>>> sv/upcr_req_if.sv
// ----------------------------------------------------------------------------
// upcr_req_if
// Tick channel: elapsed time and the three running byte counters.
// ----------------------------------------------------------------------------
`default_nettype none

interface upcr_req_if;
   import upcr_pkg::*;

   logic                valid;
   logic                ready;
   logic [ElapsedW-1:0] elapsed_ms;
   logic [CountW-1:0]   link_out_count;
   logic [CountW-1:0]   payload_out_count;
   logic [CountW-1:0]   total_out_count;

   modport source (
      output valid, elapsed_ms, link_out_count, payload_out_count, total_out_count,
      input  ready
   );

   modport sink (
      input  valid, elapsed_ms, link_out_count, payload_out_count, total_out_count,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/upcr_rsp_if.sv
// ----------------------------------------------------------------------------
// upcr_rsp_if
// Result channel: granted rate, clamped credit and control overhead.
// ----------------------------------------------------------------------------
`default_nettype none

interface upcr_rsp_if;
   import upcr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic        [RateW-1:0]   granted_rate;
   logic signed [CreditW-1:0] credit_level;
   logic signed [CountW-1:0]  overhead_bytes;

   modport source (
      output valid, granted_rate, credit_level, overhead_bytes,
      input  ready
   );

   modport sink (
      input  valid, granted_rate, credit_level, overhead_bytes,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/upload_credit_rate_controller_top.sv
// ----------------------------------------------------------------------------
// upload_credit_rate_controller_top
// Token bucket upload limiter: per tick it refills a signed byte credit,
// charges the bytes sent, clamps it and derives the granted rate.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  req_chan  in         valid/ready         elapsed_ms, three byte counters
//  rsp_chan  out        valid/ready         granted_rate, credit_level, overhead
//  csr_*     in         csr_wr_en only      csr_index, csr_data
//
//  One transfer per cycle unless stalled; a tick runs stages 1 to 6, then rsp.
//  A tick with zero elapsed time is taken and yields no result.
//  The credit register closes its loop in a single stage; the refill divide
//  runs ahead of it through three multiply stages and an add stage.
//  Reset is synchronous and restores registers, counters and credit.
//  A stalled result backs up the stages; req ready drops once all are full.
// ----------------------------------------------------------------------------
`default_nettype none

module upload_credit_rate_controller_top (
   input  logic                              clock,
   input  logic                              reset,
   upcr_req_if.sink                          req_chan,
   upcr_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  upcr_pkg::csr_index_type           csr_index,
   input  logic [upcr_pkg::CsrDataW-1:0]     csr_data
);
   import upcr_pkg::*;

   // configuration
   logic [QW-1:0]   max_upload_q8_ff;
   logic [MtuW-1:0] link_mtu_ff;
   logic            full_control_ff;

   // counter snapshots
   logic [CountW-1:0] last_link_ff;
   logic [CountW-1:0] last_payload_ff;
   logic [CountW-1:0] last_total_ff;

   // handshake and stage loads
   logic req_take;
   logic req_live;
   logic ld1, ld2, ld3, ld4, ld5, ld6, ld_out;

   // input deltas
   logic [CountW-1:0] d_link, d_pay, d_tot, ov_raw, charge;

   // stage 1
   logic                s1_valid_ff;
   logic [ElapsedW-1:0] s1_elapsed_ff;
   logic [CountW-1:0]   s1_charge_ff;
   logic [CountW-1:0]   s1_ov_ff;

   // stage 2
   logic              s2_valid_ff;
   logic [39:0]       s2_prod_ff;
   logic [62:0]       s2_ovp_ff;
   logic [2:0]        s2_ovlow_ff;
   logic              s2_ovpos_ff;
   logic [48:0]       s2_qp_ff;
   logic [CountW-1:0] s2_charge_ff;
   logic [CountW-1:0] s2_ov_ff;

   // stage 3
   logic [18:0] yh;
   logic [19:0] yl;
   logic [28:0] ov_quot;
   logic [2:0]  ov_rem;
   logic [21:0] q_quot;
   logic [2:0]  q_rem;

   logic              s3_valid_ff;
   logic [32:0]       s3_a_ff;
   logic [25:0]       s3_r_ff;
   logic [30:0]       s3_ovsub_ff;
   logic [23:0]       s3_fr_ff;
   logic [CountW-1:0] s3_charge_ff;
   logic [CountW-1:0] s3_ov_ff;

   // stage 4
   logic              s4_valid_ff;
   logic [53:0]       s4_t_ff;
   logic [32:0]       s4_a_ff;
   logic [30:0]       s4_ovsub_ff;
   logic [23:0]       s4_fr_ff;
   logic [CountW-1:0] s4_charge_ff;
   logic [CountW-1:0] s4_ov_ff;

   // stage 5
   logic              s5_valid_ff;
   logic [35:0]       s5_net_ff;
   logic [30:0]       s5_ovsub_ff;
   logic [23:0]       s5_fr_ff;
   logic [CountW-1:0] s5_ov_ff;

   // stage 6: credit loop
   logic signed [CreditW-1:0] credit_ff;
   logic signed [CreditW-1:0] credit_in;
   logic signed [CreditW-1:0] credit_sum;
   logic signed [CreditW-1:0] credit_cap;
   logic signed [CreditW-1:0] credit_mtu;
   logic signed [CreditW-1:0] credit_low;
   logic                      s6_valid_ff;
   logic [30:0]               s6_ovsub_ff;
   logic [23:0]               s6_fr_ff;
   logic [CountW-1:0]         s6_ov_ff;

   // result
   logic signed [CreditW-1:0] eff_in;
   logic signed [CreditW-1:0] floor_rate;
   logic                      rsp_valid_ff;
   logic [RateW-1:0]          rsp_granted_ff;
   logic signed [CreditW-1:0] rsp_credit_ff;
   logic signed [CountW-1:0]  rsp_overhead_ff;

   // ---------------------------------------------------------------- control
   assign ld_out = !rsp_valid_ff || rsp_chan.ready;
   assign ld6    = !s6_valid_ff || ld_out;
   assign ld5    = !s5_valid_ff || ld6;
   assign ld4    = !s4_valid_ff || ld5;
   assign ld3    = !s3_valid_ff || ld4;
   assign ld2    = !s2_valid_ff || ld3;
   assign ld1    = !s1_valid_ff || ld2;

   assign req_chan.ready = ld1;
   assign req_take       = req_chan.valid && ld1;
   assign req_live       = req_take && (req_chan.elapsed_ms != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_upload_q8_ff <= '0;
         link_mtu_ff      <= LINK_MTU_RESET;
         full_control_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_UPLOAD_Q8: max_upload_q8_ff <= csr_data[QW-1:0];
            CSR_LINK_MTU:      link_mtu_ff      <= csr_data[MtuW-1:0];
            CSR_FULL_CONTROL:  full_control_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 1
   assign d_link = req_chan.link_out_count - last_link_ff;
   assign d_pay  = req_chan.payload_out_count - last_payload_ff;
   assign d_tot  = req_chan.total_out_count - last_total_ff;
   assign ov_raw = d_tot - d_pay;
   assign charge = full_control_ff ? d_link : d_pay;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_link_ff    <= '0;
         last_payload_ff <= '0;
         last_total_ff   <= '0;
      end else if (req_live) begin
         last_link_ff    <= req_chan.link_out_count;
         last_payload_ff <= req_chan.payload_out_count;
         last_total_ff   <= req_chan.total_out_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ld1) begin
         s1_valid_ff <= req_live;
      end
      if (ld1) begin
         s1_elapsed_ff <= req_chan.elapsed_ms;
         s1_charge_ff  <= charge;
         s1_ov_ff      <= ov_raw;
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ld2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (ld2) begin
         s2_prod_ff   <= 40'(max_upload_q8_ff) * 40'(s1_elapsed_ff);
         s2_ovp_ff    <= 63'(s1_ov_ff[30:0]) * 63'(RECIP_5_W31);
         s2_ovlow_ff  <= s1_ov_ff[2:0];
         s2_ovpos_ff  <= full_control_ff && !s1_ov_ff[31] && (s1_ov_ff != '0);
         s2_qp_ff     <= 49'(max_upload_q8_ff) * 49'(RECIP_5_W24);
         s2_charge_ff <= s1_charge_ff;
         s2_ov_ff     <= s1_ov_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // refill = floor(q*e/250) = floor(y/125) with y = (q*e) >> 1
   assign yh      = s2_prod_ff[39:21];
   assign yl      = s2_prod_ff[20:1];
   assign ov_quot = s2_ovp_ff[62:34];
   assign ov_rem  = 3'(s2_ovlow_ff - 3'(ov_quot[2:0] * 3'd5));
   assign q_quot  = s2_qp_ff[48:27];
   assign q_rem   = 3'(max_upload_q8_ff[2:0] - 3'(q_quot[2:0] * 3'd5));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ld3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (ld3) begin
         s3_a_ff      <= 33'(yh) * 33'(DIV125_HI_QUOT);
         s3_r_ff      <= 26'(yh) * 26'(DIV125_HI_REM) + 26'(yl);
         s3_ovsub_ff  <= s2_ovpos_ff ? {ov_quot, frac_4_5(ov_rem)} : '0;
         s3_fr_ff     <= {q_quot, frac_4_5(q_rem)};
         s3_charge_ff <= s2_charge_ff;
         s3_ov_ff     <= s2_ov_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (ld4) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (ld4) begin
         s4_t_ff      <= 54'(s3_r_ff) * 54'(RECIP_125);
         s4_a_ff      <= s3_a_ff;
         s4_ovsub_ff  <= s3_ovsub_ff;
         s4_fr_ff     <= s3_fr_ff;
         s4_charge_ff <= s3_charge_ff;
         s4_ov_ff     <= s3_ov_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (ld5) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (ld5) begin
         s5_net_ff   <= 36'(s4_a_ff) + 36'(s4_t_ff[53:34]) - 36'(s4_charge_ff);
         s5_ovsub_ff <= s4_ovsub_ff;
         s5_fr_ff    <= s4_fr_ff;
         s5_ov_ff    <= s4_ov_ff;
      end
   end

   // ---------------------------------------------------------------- stage 6
   assign credit_sum = credit_ff + CreditW'($signed(s5_net_ff));
   assign credit_cap = $signed(CreditW'({max_upload_q8_ff, 2'b00}));
   assign credit_mtu = $signed(CreditW'(link_mtu_ff)) - $signed(HEADER_BYTES);
   assign credit_low = -$signed(CreditW'({max_upload_q8_ff, 1'b0}));

   always_comb begin
      credit_in = credit_sum;
      if (credit_sum > credit_cap) begin
         credit_in = credit_cap;
         if (credit_in < credit_mtu) begin
            credit_in = credit_mtu;
         end
      end
      if (credit_in < credit_low) begin
         credit_in = credit_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         credit_ff   <= '0;
      end else if (ld6) begin
         s6_valid_ff <= s5_valid_ff;
         if (s5_valid_ff) begin
            credit_ff <= credit_in;
         end
      end
      if (ld6) begin
         s6_ovsub_ff <= s5_ovsub_ff;
         s6_fr_ff    <= s5_fr_ff;
         s6_ov_ff    <= s5_ov_ff;
      end
   end

   // ---------------------------------------------------------------- result
   assign floor_rate = $signed(CreditW'(s6_fr_ff));

   always_comb begin
      eff_in = credit_ff - $signed(CreditW'(s6_ovsub_ff));
      if (eff_in <= floor_rate) begin
         eff_in = floor_rate;
      end
      if (eff_in < $signed(MIN_RATE)) begin
         eff_in = $signed(MIN_RATE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ld_out) begin
         rsp_valid_ff <= s6_valid_ff;
      end
      if (ld_out) begin
         rsp_granted_ff  <= eff_in[RateW-1:0];
         rsp_credit_ff   <= credit_ff;
         rsp_overhead_ff <= $signed(s6_ov_ff);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.granted_rate   = rsp_granted_ff;
   assign rsp_chan.credit_level   = rsp_credit_ff;
   assign rsp_chan.overhead_bytes = rsp_overhead_ff;

endmodule

`default_nettype wire

>>> sv/upcr_checker.sv
// ----------------------------------------------------------------------------
// upcr_checker
// Port-level checks of the upload credit rate controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module upcr_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic        [upcr_pkg::RateW-1:0]   rsp_granted_rate,
   input  logic signed [upcr_pkg::CreditW-1:0] rsp_credit_level,
   input  logic signed [upcr_pkg::CountW-1:0]  rsp_overhead_bytes
);
   import upcr_pkg::*;

   // hold a stalled result and its payload
   `UPCR_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_rate) &&
      $stable(rsp_credit_level) && $stable(rsp_overhead_bytes))

   // drop req ready only while a result waits for its transfer
   `UPCR_ASSERT(a_ready_backpressure, clock, reset, !req_ready |-> rsp_valid && !rsp_ready)

   // never grant below the minimum rate
   `UPCR_ASSERT(a_rate_floor, clock, reset, rsp_valid |-> rsp_granted_rate >= MIN_RATE[RateW-1:0])

   // no result right after reset
   `UPCR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind upload_credit_rate_controller_top upcr_checker u_upcr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_granted_rate   (rsp_chan.granted_rate),
   .rsp_credit_level   (rsp_chan.credit_level),
   .rsp_overhead_bytes (rsp_chan.overhead_bytes)
);

`default_nettype wire

>>> tb/upload_credit_rate_controller_top_test.sv
// ----------------------------------------------------------------------------
// upload_credit_rate_controller_top_test
// Self-checking bench for the upload credit rate controller. A running model
// of the byte credit bucket predicts granted rate, clamped credit and control
// overhead for every accepted tick with nonzero elapsed time. A checker
// compares each result transfer, in order, with the oldest prediction.
// Directed ticks cover field limits, wrapping counters, the MTU raise of the
// capped credit, overhead truncation, mode switching and zero elapsed time.
// Random phases follow under several register settings, with bursty ticks,
// a stalling receiver and one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module upload_credit_rate_controller_top_test;
   import upcr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_TICKS = 125;

   typedef struct {
      logic        [RateW-1:0]   rate;
      logic signed [CreditW-1:0] credit;
      logic signed [CountW-1:0]  overhead;
   } grant_rec_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   csr_index_type csr_index;
   logic [CsrDataW-1:0] csr_data;

   upcr_req_if req_if ();
   upcr_rsp_if rsp_if ();

   upload_credit_rate_controller_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // bucket model state and register copies
   bit [QW-1:0]     cfg_max_q8 = '0;
   bit [MtuW-1:0]   cfg_mtu    = LINK_MTU_RESET;
   bit              cfg_full   = 1'b0;
   longint          bucket_credit = 0;
   bit [CountW-1:0] seen_link    = '0;
   bit [CountW-1:0] seen_payload = '0;
   bit [CountW-1:0] seen_total   = '0;

   grant_rec_type grants_due[$];
   int            mismatch_count = 0;
   int            cycle_count    = 0;

   // stimulus control
   bit [CountW-1:0] tx_link    = '0;
   bit [CountW-1:0] tx_payload = '0;
   bit [CountW-1:0] tx_total   = '0;
   bit              gaps_enabled = 1'b1;
   int              burst_left   = 0;
   int              rx_mode      = 1;
   bit              hold_off_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL upload_credit_rate_controller_top");
         $finish;
      end
   end

   function automatic void bucket_advance(input bit [ElapsedW-1:0] el,
                                          input bit [CountW-1:0] link,
                                          input bit [CountW-1:0] pay,
                                          input bit [CountW-1:0] tot);
      bit [CountW-1:0] d_link;
      bit [CountW-1:0] d_pay;
      bit [CountW-1:0] d_tot;
      bit [CountW-1:0] ov_raw;
      longint q;
      longint ov;
      longint ov80;
      longint cap;
      longint eff;
      longint floor_rate;
      grant_rec_type rec;
      if (el == 0)
         return;
      d_link = link - seen_link;
      d_pay  = pay - seen_payload;
      d_tot  = tot - seen_total;
      ov_raw = d_tot - d_pay;
      ov     = longint'($signed(ov_raw));
      q      = longint'(cfg_max_q8);
      bucket_credit += (4 * q * longint'(el)) / 1000;
      bucket_credit -= cfg_full ? longint'(d_link) : longint'(d_pay);
      seen_link    = link;
      seen_payload = pay;
      seen_total   = tot;
      cap = 4 * q;
      if (bucket_credit > cap) begin
         bucket_credit = cap;
         if (bucket_credit < longint'(cfg_mtu) - 40)
            bucket_credit = longint'(cfg_mtu) - 40;
      end
      if (bucket_credit < -2 * q)
         bucket_credit = -2 * q;
      eff = bucket_credit;
      if (cfg_full) begin
         ov80 = (8 * ov) / 10;
         if (ov80 > 0)
            eff -= ov80;
      end
      floor_rate = (4 * q) / 5;
      if (eff <= floor_rate)
         eff = floor_rate;
      if (eff < 1024)
         eff = 1024;
      rec.rate     = eff[RateW-1:0];
      rec.credit   = bucket_credit[CreditW-1:0];
      rec.overhead = ov_raw;
      grants_due.push_back(rec);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         bucket_advance(req_if.elapsed_ms, req_if.link_out_count,
                        req_if.payload_out_count, req_if.total_out_count);
   end

   always @(posedge clock) begin
      grant_rec_type exp_rec;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (grants_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: result with none pending: rate %0d credit %0d ovh %0d",
                        rsp_if.granted_rate, rsp_if.credit_level,
                        rsp_if.overhead_bytes);
         end else begin
            exp_rec = grants_due.pop_front();
            if (rsp_if.granted_rate !== exp_rec.rate ||
                rsp_if.credit_level !== exp_rec.credit ||
                rsp_if.overhead_bytes !== exp_rec.overhead) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: rate %0d/%0d credit %0d/%0d ovh %0d/%0d (exp/got)",
                           exp_rec.rate, rsp_if.granted_rate,
                           exp_rec.credit, rsp_if.credit_level,
                           exp_rec.overhead, rsp_if.overhead_bytes);
            end
         end
      end
   end

   // receiver: stall pattern per mode, long hold-off on request
   initial begin : receiver
      int hold;
      int rx_phase;
      rx_phase = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_phase++;
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            for (hold = 0; hold < HOLD_CYCLES; hold++)
               @(posedge clock);
         end else begin
            case (rx_mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 9) < 6);
               2: rsp_if.ready <= ((rx_phase % 7) < 4);
               default: rsp_if.ready <= ($urandom_range(0, 15) == 0) ? 1'b0 :
                                        ((rx_phase % 32) > 5);
            endcase
         end
      end
   end

   task automatic write_config(input bit [QW-1:0] q, input bit [MtuW-1:0] mtu,
                               input bit full);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAX_UPLOAD_Q8;
      csr_data  <= q;
      @(posedge clock);
      cfg_max_q8 = q;
      csr_index <= CSR_LINK_MTU;
      csr_data  <= CsrDataW'(mtu);
      @(posedge clock);
      cfg_mtu = mtu;
      csr_index <= CSR_FULL_CONTROL;
      csr_data  <= CsrDataW'(full);
      @(posedge clock);
      cfg_full = full;
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_tick(input bit [ElapsedW-1:0] el, input bit [CountW-1:0] link,
                            input bit [CountW-1:0] pay, input bit [CountW-1:0] tot);
      req_if.valid             <= 1'b1;
      req_if.elapsed_ms        <= el;
      req_if.link_out_count    <= link;
      req_if.payload_out_count <= pay;
      req_if.total_out_count   <= tot;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   task automatic offer_tick(input bit [ElapsedW-1:0] el, input bit [CountW-1:0] link,
                             input bit [CountW-1:0] pay, input bit [CountW-1:0] tot);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = gaps_enabled ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      tx_link    = link;
      tx_payload = pay;
      tx_total   = tot;
      send_tick(el, link, pay, tot);
   endtask

   task automatic advance_counts(input bit [ElapsedW-1:0] el, input int unsigned pay_d,
                                 input int ovh_d, input int unsigned hdr_d);
      offer_tick(el, tx_link + pay_d + ovh_d + hdr_d, tx_payload + pay_d,
                 tx_total + pay_d + ovh_d);
   endtask

   task automatic finish_phase();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (grants_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_tick(input bit shaped);
      bit [ElapsedW-1:0] el;
      int unsigned pay_d;
      int unsigned near;
      int unsigned hdr_d;
      int ovh_d;
      longint refill;
      case ($urandom_range(0, 19))
         0:       el = '0;
         1:       el = ElapsedW'($urandom);
         2:       el = '1;
         default: el = ElapsedW'($urandom_range(1, 1000));
      endcase
      if (shaped) begin
         refill = (4 * longint'(cfg_max_q8) * longint'(el)) / 1000;
         near = (refill > 64'h3FFF_FFFF) ? 32'h3FFF_FFFF : refill[31:0];
         case ($urandom_range(0, 3))
            0: pay_d = $urandom_range(0, 1000);
            1: pay_d = $urandom_range(0, 2 * near);
            2: pay_d = $urandom_range(0, 1 << 22);
            default: pay_d = 0;
         endcase
         ovh_d = $urandom_range(0, 4000);
         hdr_d = pay_d / 20 + $urandom_range(0, 100);
         advance_counts(el, pay_d, ovh_d, hdr_d);
      end else begin
         offer_tick(el, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic test_reset_values();
      offer_tick(16'd0, 32'd5, 32'd5, 32'd5);
      offer_tick(16'd1, 32'd100, 32'd80, 32'd90);
      offer_tick(16'hFFFF, 32'd0, 32'd0, 32'd0);
      finish_phase();
   endtask

   task automatic test_field_limits();
      write_config(24'hFF_FFFF, 16'hFFFF, 1'b1);
      offer_tick(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_tick(16'd1, 32'd0, 32'd0, 32'h7FFF_FFFF);
      offer_tick(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
      offer_tick(16'd1, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      finish_phase();
      write_config(24'd0, 16'hFFFF, 1'b0);
      advance_counts(16'd1000, 0, 0, 0);
      finish_phase();
   endtask

   task automatic test_mtu_raise();
      write_config(24'd0, 16'd41, 1'b0);
      advance_counts(16'd100, 0, 0, 0);
      finish_phase();
      write_config(24'd10, 16'hFFFF, 1'b0);
      advance_counts(16'd1000, 0, 0, 0);
      advance_counts(16'd1000, 0, 0, 0);
      finish_phase();
   endtask

   task automatic test_overhead_truncation();
      write_config(24'd25600, 16'd1500, 1'b1);
      advance_counts(16'd100, 500, 1, 50);
      advance_counts(16'd100, 500, 4, 50);
      advance_counts(16'd100, 500, 9, 50);
      advance_counts(16'd100, 500, -9, 50);
      advance_counts(16'd100, 500, 13, 50);
      finish_phase();
   endtask

   task automatic test_mode_switch();
      write_config(24'd25600, 16'd1500, 1'b0);
      advance_counts(16'd100, 2000, 300, 5000);
      advance_counts(16'd200, 100, 0, 90000);
      finish_phase();
      write_config(24'd25600, 16'd1500, 1'b1);
      advance_counts(16'd100, 2000, 300, 5000);
      advance_counts(16'd200, 100, 0, 90000);
      finish_phase();
   endtask

   task automatic test_zero_elapsed();
      advance_counts(16'd0, 7000, 70, 700);
      advance_counts(16'd50, 10, 10, 10);
      finish_phase();
   endtask

   task automatic test_random_traffic();
      int phase;
      int n;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_config(24'd0, 16'd41, 1'b0);
            1: write_config(24'hFF_FFFF, 16'hFFFF, 1'b1);
            2: write_config(24'd25600, 16'd1500, 1'b1);
            3: write_config(24'd2560, 16'd1500, 1'b0);
            default: write_config(QW'($urandom), MtuW'($urandom_range(41, 65535)),
                                  1'($urandom));
         endcase
         rx_mode      = phase % 4;
         gaps_enabled = (phase != 3) && (phase != 4);
         burst_left   = 0;
         tx_link      = $urandom;
         tx_payload   = $urandom;
         tx_total     = $urandom;
         for (n = 0; n < RANDOM_TICKS; n++)
            random_tick($urandom_range(0, 7) != 0);
         finish_phase();
      end
   endtask

   task automatic test_backpressure();
      int n;
      write_config(24'd25600, 16'd1500, 1'b1);
      rx_mode      = 0;
      gaps_enabled = 1'b0;
      hold_off_req = 1'b1;
      for (n = 0; n < 80; n++)
         random_tick(1'b1);
      finish_phase();
      gaps_enabled = 1'b1;
      rx_mode      = 1;
   endtask

   initial begin
      reset                    <= 1'b1;
      csr_wr_en                <= 1'b0;
      csr_index                <= CSR_MAX_UPLOAD_Q8;
      csr_data                 <= '0;
      req_if.valid             <= 1'b0;
      req_if.elapsed_ms        <= '0;
      req_if.link_out_count    <= '0;
      req_if.payload_out_count <= '0;
      req_if.total_out_count   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_field_limits();
      test_mtu_raise();
      test_overhead_truncation();
      test_mode_switch();
      test_zero_elapsed();
      test_backpressure();
      test_random_traffic();
      finish_phase();
      if (mismatch_count == 0 && grants_due.size() == 0) begin
         $display("PASS upload_credit_rate_controller_top");
      end else begin
         $display("FAIL upload_credit_rate_controller_top");
      end
      $finish;
   end

endmodule

`default_nettype wire
